FILE: rtl/bnf_pkg.sv
// Shared constants and codes for the biquad notch filter core.
package bnf_pkg;

  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned COEF_WIDTH   = 24;
  localparam int unsigned COEF_FRAC    = 16;

  // Signed width of the expanded coefficients (a, 2(a-8), -2(a-8), b-a).
  localparam int unsigned CEXT_WIDTH = COEF_WIDTH + 3;
  localparam int unsigned PROD_WIDTH = CEXT_WIDTH + SAMPLE_WIDTH;
  localparam int unsigned ACC_WIDTH  = PROD_WIDTH + 3;
  localparam int unsigned DEN_WIDTH  = COEF_WIDTH + 1;
  localparam int unsigned QCNT_WIDTH = $clog2(SAMPLE_WIDTH);
  localparam int unsigned DATA_BYTES = (SAMPLE_WIDTH + 7) / 8;
  localparam int unsigned TDATA_WIDTH = DATA_BYTES * 8;

  // Register indexes of the configuration port.
  localparam int unsigned CFG_IDX_WIDTH = 1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_BETA  = 1'b1;

  localparam logic [COEF_WIDTH-1:0] ALPHA_RESET = COEF_WIDTH'(4 << COEF_FRAC);
  localparam logic [COEF_WIDTH-1:0] BETA_RESET  = '0;

  // Twice the constant 8.0 in the coefficient format.
  localparam logic signed [CEXT_WIDTH-1:0] SIXTEEN_Q = CEXT_WIDTH'(16 << COEF_FRAC);

endpackage

FILE: rtl/biquad_notch_filter_core.sv
// Top level of the biquad notch filter: shared multiply-accumulate and serial divider.
//
// The core filters one signed Q1.15 sample per transfer with a second-order notch,
//   y0 = (a*x0 + 2(a-8)*x1 + a*x2 - 2(a-8)*y1 - (a-b)*y2) / (a+b),
// where a (alpha_coef) and b (beta_coef) are unsigned Q8.16 values written through
// the configuration port (index 0 is alpha, index 1 is beta; reset values 4.0 and 0).
// Configuration must only be written while the core is idle. The quotient is
// truncated toward zero and saturated to the 16-bit range; a zero denominator
// gives zero. One small sequencer drives a single 27x16 signed multiplier for the
// five products (one per cycle, then a drain step for the product register),
// then a check step forms the magnitude and the overflow test, then a restoring
// divider resolves one quotient bit per cycle for all sixteen bits, then a write
// step loads the output register, waiting while an older result is unread there.
// The divider is skipped when the quotient overflows or the denominator is zero.
// s_axis_tready_o is high only while the core is idle, so a new sample is taken
// only after the last one is loaded, in the cycle after the load at the earliest.
// The result sits in an output register, so the next sample may be taken while
// it waits to be read.
// The four history samples are cleared at reset and updated when the result is
// loaded into the output register.
module biquad_notch_filter_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // Input stream. tdata: sample_in [15:0].
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  input  logic [bnf_pkg::TDATA_WIDTH-1:0]         s_axis_tdata_i,
  // Output stream. tdata: sample_out [15:0].
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  output logic [bnf_pkg::TDATA_WIDTH-1:0]         m_axis_tdata_o,
  // Configuration write port.
  input  logic                                    cfg_we_i,
  input  logic [bnf_pkg::CFG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [bnf_pkg::COEF_WIDTH-1:0]          cfg_wdata_i
);

  localparam int unsigned SW = bnf_pkg::SAMPLE_WIDTH;
  localparam int unsigned CW = bnf_pkg::COEF_WIDTH;
  localparam int unsigned EW = bnf_pkg::CEXT_WIDTH;
  localparam int unsigned PW = bnf_pkg::PROD_WIDTH;
  localparam int unsigned AW = bnf_pkg::ACC_WIDTH;
  localparam int unsigned DW = bnf_pkg::DEN_WIDTH;
  localparam int unsigned QW = bnf_pkg::QCNT_WIDTH;

  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [QW-1:0] QBIT_LAST = QW'(SW - 1);
  localparam logic [2:0] MAC_LAST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_CHECK,
    ST_DIV,
    ST_WRITE
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [CW-1:0] alpha_q, beta_q;

  // History: x1, x2 (inputs) and y1, y2 (outputs).
  logic signed [SW-1:0] x0_q, x1_q, x2_q, y1_q, y2_q;

  // Coefficients latched at the input transfer.
  logic signed [EW-1:0] ca_q, c1_q, nc1_q, cba_q;
  logic [DW-1:0] den_q;

  // Datapath registers.
  logic [2:0]           step_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [AW-1:0]        rem_q, dsh_q;
  logic [SW-1:0]        quo_q;
  logic [QW-1:0]        qcnt_q;
  logic                 neg_q, sat_q, zero_q;
  logic                 m_valid_q;
  logic [SW-1:0]        m_data_q;

  logic s_hs, out_load;
  logic signed [EW-1:0] coef_sel;
  logic signed [SW-1:0] smp_sel;
  logic signed [PW-1:0] prod_d;
  logic signed [EW-1:0] ca_d, c1_d, cba_d;
  logic [AW-1:0]        mag;
  logic [AW-1:0]        den_ext;
  logic                 div_ge;
  logic [SW-1:0]        quo_neg;
  logic signed [SW-1:0] result;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs            = s_axis_tvalid_i & s_axis_tready_o;
  assign out_load        = (state_q == ST_WRITE) && (!m_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = bnf_pkg::TDATA_WIDTH'(m_data_q);

  // Expanded coefficients for the next sample.
  assign ca_d  = {3'b000, alpha_q};
  assign c1_d  = {2'b00, alpha_q, 1'b0} - bnf_pkg::SIXTEEN_Q;
  assign cba_d = {3'b000, beta_q} - {3'b000, alpha_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (step_q)
      3'd0: begin
        coef_sel = ca_q;
        smp_sel  = x0_q;
      end
      3'd1: begin
        coef_sel = c1_q;
        smp_sel  = x1_q;
      end
      3'd2: begin
        coef_sel = ca_q;
        smp_sel  = x2_q;
      end
      3'd3: begin
        coef_sel = nc1_q;
        smp_sel  = y1_q;
      end
      3'd4: begin
        coef_sel = cba_q;
        smp_sel  = y2_q;
      end
      default: begin
        coef_sel = '0;
        smp_sel  = '0;
      end
    endcase
  end

  assign prod_d = coef_sel * smp_sel;

  // Numerator magnitude and the shifted denominator for the overflow test.
  assign mag     = acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
  assign den_ext = AW'(den_q) << SW;
  assign div_ge  = (rem_q >= dsh_q);

  // Sign and saturation of the quotient.
  assign quo_neg = SW'(-quo_q);
  always_comb begin
    if (zero_q) begin
      result = '0;
    end else if (!neg_q) begin
      result = (sat_q || quo_q[SW-1]) ? SMP_MAX : $signed(quo_q);
    end else if (sat_q || (quo_q > {1'b1, {(SW-1){1'b0}}})) begin
      result = SMP_MIN;
    end else begin
      result = $signed(quo_neg);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= bnf_pkg::ALPHA_RESET;
      beta_q  <= bnf_pkg::BETA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bnf_pkg::REG_ALPHA: alpha_q <= cfg_wdata_i;
        bnf_pkg::REG_BETA:  beta_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Payload registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      x0_q  <= $signed(s_axis_tdata_i[SW-1:0]);
      ca_q  <= ca_d;
      c1_q  <= c1_d;
      nc1_q <= -c1_d;
      cba_q <= cba_d;
      den_q <= {1'b0, alpha_q} + {1'b0, beta_q};
    end
    if (state_q == ST_MAC) begin
      prod_q <= prod_d;
    end
  end

  // Sequencer, history and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      acc_q     <= '0;
      rem_q     <= '0;
      dsh_q     <= '0;
      quo_q     <= '0;
      qcnt_q    <= '0;
      neg_q     <= 1'b0;
      sat_q     <= 1'b0;
      zero_q    <= 1'b0;
      x1_q      <= '0;
      x2_q      <= '0;
      y1_q      <= '0;
      y2_q      <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_hs) begin
            step_q  <= '0;
            acc_q   <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          // The product of the previous step is added while the next one forms.
          if (step_q != 3'd0) begin
            acc_q <= acc_q + {{3{prod_q[PW-1]}}, prod_q};
          end
          step_q <= step_q + 3'd1;
          if (step_q == MAC_LAST) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          neg_q  <= acc_q[AW-1];
          zero_q <= (den_q == '0);
          sat_q  <= (mag >= den_ext);
          rem_q  <= mag;
          dsh_q  <= AW'(den_q) << (SW - 1);
          quo_q  <= '0;
          qcnt_q <= '0;
          if ((den_q == '0) || (mag >= den_ext)) begin
            state_q <= ST_WRITE;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_ge) begin
            rem_q <= rem_q - dsh_q;
          end
          quo_q  <= {quo_q[SW-2:0], div_ge};
          dsh_q  <= dsh_q >> 1;
          qcnt_q <= qcnt_q + QW'(1);
          if (qcnt_q == QBIT_LAST) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (out_load) begin
            m_valid_q <= 1'b1;
            m_data_q  <= result;
            x2_q      <= x1_q;
            x1_q      <= x0_q;
            y2_q      <= y1_q;
            y1_q      <= result;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // An input transfer starts a computation that blocks the next one.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_hs |=> !s_axis_tready_o)
    else $error("input accepted while a sample is in progress");

  // The restoring divider keeps its remainder below twice the shifted divisor.
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < (dsh_q << 1)))
    else $error("divider remainder out of range");

  // A zero denominator yields a zero sample.
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && zero_q) |=> (m_data_q == '0))
    else $error("zero denominator did not give zero");

  // A new result only appears from the write-back step.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(out_load))
    else $error("output valid raised outside write-back");

endmodule
